>>> hw/rtl/brf_pkg.sv
// shared types and constants of the bitmap run fill block
`default_nettype none

package brf_pkg;

    localparam int START_W   = 12;
    localparam int COUNT_W   = 13;
    localparam int IDX_W     = 6;
    localparam int VAL_W     = 64;
    localparam int ST_W      = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 72;
    localparam int Q_W       = 10;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_RUN
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic emit_status;
        logic start_run;
        logic run_step;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic empty;
        logic range_err;
        logic final_word;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/bitmap_run_fill.sv
// top level of the bitmap run fill block
//
// channel  dir  handshake                tdata / tuser / tlast
// s_axis   in   s_axis_tvalid/tready     first_bit, bit_count, fill_value
// m_axis   out  m_axis_tvalid/tready     word_index, word_value; status; last_word
//
// a request is loaded, checked and set up, then the words it touches are read, masked
// and written back in order; an empty or rejected run gives a single status beat
// after reset the bitmap ram is swept to zero, one word at a time, with
// s_axis_tready low
// the result register frees the next request while the last beat waits
// a stalled m_axis holds the word walk in place
`default_nettype none

module bitmap_run_fill
    import brf_pkg::*;
#(
    parameter int MAP_BITS  = 4096,
    parameter int WORD_BITS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // first_bit[11:0], bit_count[24:12], fill_value[25]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // word_index[5:0], word_value[69:6]
    output logic      [M_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic      [ST_W-1:0]      m_axis_tuser,
    output logic                      m_axis_tlast
);

    cmd_t             cmd;
    sts_t             sts;
    logic [IDX_W-1:0] out_idx;
    logic [VAL_W-1:0] out_val;

    brf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    brf_dp #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_start  (s_axis_tdata[START_W-1:0]),
        .in_count  (s_axis_tdata[START_W +: COUNT_W]),
        .in_fill   (s_axis_tdata[START_W+COUNT_W]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_idx   (out_idx),
        .out_val   (out_val),
        .out_st    (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_val, out_idx};

endmodule

`default_nettype wire

>>> hw/rtl/brf_ram.sv
// generic single write port ram with registered read
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/brf_ctrl.sv
// controller state machine of the bitmap run fill block
`default_nettype none

module brf_ctrl
    import brf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.empty || sts.range_err)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit_status = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.start_run = 1'b1;
                    state_next    = S_RUN;
                end
            end
            S_RUN:
            begin
                if (sts.out_free)
                begin
                    cmd.run_step = 1'b1;
                    if (sts.final_word)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/brf_dp.sv
// datapath: request registers, word masking, bitmap ram and result register
`default_nettype none

module brf_dp
    import brf_pkg::*;
#(
    parameter int MAP_BITS  = 4096,
    parameter int WORD_BITS = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    output sts_t                        sts,
    input  wire logic [START_W-1:0]     in_start,
    input  wire logic [COUNT_W-1:0]     in_count,
    input  wire logic                   in_fill,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [IDX_W-1:0]       out_idx,
    output logic      [VAL_W-1:0]       out_val,
    output logic      [ST_W-1:0]        out_st,
    output logic                        out_last
);

    localparam int NUM_WORDS = MAP_BITS / WORD_BITS;
    localparam int AW        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int PW        = $clog2(WORD_BITS);
    localparam int EW        = PW + 1;
    // start / WORD_BITS as a reciprocal multiply, exact for 12 bit starts
    localparam int RSHIFT    = 20;
    localparam int RECIP_W   = 18;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RSHIFT) + WORD_BITS - 1) / WORD_BITS);
    localparam int PROD_W    = START_W + RECIP_W;

    logic [START_W-1:0]   start_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 fill_reg;
    logic [Q_W-1:0]       q_reg;
    logic [AW-1:0]        cur_w_reg, cur_w_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [COUNT_W-1:0]   left_reg, left_next;

    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_idx_reg, out_idx_next;
    logic [VAL_W-1:0]     out_val_reg, out_val_next;
    logic [ST_W-1:0]      out_st_reg, out_st_next;
    logic                 out_last_reg, out_last_next;

    logic [PROD_W-1:0]    prod;
    logic [START_W-1:0]   pos_full;
    logic [START_W+1:0]   run_end;
    logic [EW-1:0]        room;
    logic [COUNT_W-1:0]   n_full;
    logic [EW-1:0]        n;
    logic [EW-1:0]        bit_end;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] new_word;
    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        raddr;
    logic [31:0]          idx_wide;
    logic                 out_free;

    assign prod     = PROD_W'(in_start) * PROD_W'(RECIP);
    assign pos_full = start_reg - START_W'(q_reg * WORD_BITS);
    assign run_end  = (START_W+2)'(start_reg) + (START_W+2)'(count_reg);
    assign out_free = !out_valid_reg || out_ready;

    // bits that fit in the current word
    assign room    = EW'(WORD_BITS) - EW'(pos_reg);
    assign n_full  = (left_reg < COUNT_W'(room)) ? left_reg : COUNT_W'(room);
    assign n       = n_full[EW-1:0];
    assign bit_end = EW'(pos_reg) + n;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            mask[i] = (EW'(i) >= EW'(pos_reg)) && (EW'(i) < bit_end);
        end
    end

    assign new_word = fill_reg ? (rdata | mask) : (rdata & ~mask);

    assign ram_we    = cmd.clr_step || cmd.run_step;
    assign ram_wdata = cmd.run_step ? new_word : '0;

    always_comb
    begin
        raddr = cur_w_reg;
        if (cmd.start_run)
        begin
            raddr = AW'(q_reg);
        end
        else if (cmd.run_step)
        begin
            raddr = cur_w_reg + AW'(1);
        end
    end

    brf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_w_reg),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign idx_wide = 32'(cur_w_reg);

    always_comb
    begin
        cur_w_next = cur_w_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        if (cmd.clr_step)
        begin
            cur_w_next = cur_w_reg + AW'(1);
        end
        else if (cmd.start_run)
        begin
            cur_w_next = AW'(q_reg);
            pos_next   = pos_full[PW-1:0];
            left_next  = count_reg;
        end
        else if (cmd.run_step)
        begin
            cur_w_next = cur_w_reg + AW'(1);
            pos_next   = '0;
            left_next  = left_reg - n_full;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        out_last_next  = out_last_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit_status)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = '0;
            out_val_next   = '0;
            out_st_next    = (count_reg == '0) ? ST_EMPTY : ST_RANGE;
            out_last_next  = 1'b1;
        end
        else if (cmd.run_step)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = idx_wide[IDX_W-1:0];
            out_val_next   = VAL_W'(new_word);
            out_st_next    = ST_OK;
            out_last_next  = sts.final_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_w_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_w_reg     <= cur_w_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg <= in_start;
            count_reg <= in_count;
            fill_reg  <= in_fill;
            q_reg     <= prod[RSHIFT +: Q_W];
        end
        pos_reg      <= pos_next;
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        sts            = '0;
        sts.clr_done   = (cur_w_reg == AW'(NUM_WORDS - 1));
        sts.empty      = (count_reg == '0);
        sts.range_err  = (32'(run_end) > MAP_BITS);
        sts.final_word = (left_reg <= COUNT_W'(room));
        sts.out_free   = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_idx   = out_idx_reg;
    assign out_val   = out_val_reg;
    assign out_st    = out_st_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/brf_chk.sv
// port checker for the bitmap run fill block, bound to the top level
`default_nettype none

module brf_chk
    import brf_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [ST_W-1:0]      m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("m_axis payload changed while stalled");

    // a request is worked alone: no second beat right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("s_axis ready right after an accepted beat");

    // empty or rejected runs give one beat with zero payload
    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |->
            m_axis_tlast && (m_axis_tdata == '0))
        else $error("status beat not single or not zero");

    // a result beat is only launched while a request is in work
    a_no_early_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result beat with no request in work");

endmodule

bind bitmap_run_fill brf_chk u_brf_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
